### hw/rtl/chl_pkg.sv
`default_nettype none
package chl_pkg;

   localparam int ENTRIES = 4096;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int LINK_W = IDX_W + 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int NAME_W = 64;
   localparam int SIZE_W = 31;
   localparam int HASH_W = 32;
   localparam int ENTRY_W = NAME_W + SIZE_W + LINK_W;
   localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
   localparam logic [LINK_W-1:0] LINK_NONE = {LINK_W{1'b1}};

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic REG_ENTRY_COUNT = 1'b0;
   localparam logic REG_HASHED_MODE = 1'b1;

   // Clears every byte after the first NUL so that equal names compare equal.
   function automatic logic [NAME_W-1:0] name_canon(input logic [NAME_W-1:0] n);
      logic [NAME_W-1:0] out;
      logic alive;
      out = '0;
      alive = 1'b1;
      for (int k = 0; k < 8; k++) begin
         if (n[8*k +: 8] == 8'd0) begin
            alive = 1'b0;
         end
         if (alive) begin
            out[8*k +: 8] = n[8*k +: 8];
         end
      end
      return out;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/chl_ram.sv
`default_nettype none
module chl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

### hw/rtl/chl_hash_mod.sv
`default_nettype none
module chl_hash_mod (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [chl_pkg::NAME_W-1:0]   key,
   input  wire logic [chl_pkg::CNT_W-1:0]    divisor,
   output logic                              done,
   output logic      [chl_pkg::IDX_W-1:0]    bucket
);
   import chl_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_HASH, ST_MOD} state_type;

   state_type           state_ff, state_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [NAME_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]    div_ff, div_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [2:0]          byte_ff, byte_in;
   logic [4:0]          bit_ff, bit_in;
   logic                done_ff, done_in;
   logic [CNT_W:0]      trial;

   // One byte of hash per cycle, then one remainder bit per cycle.
   always_comb begin
      state_in = state_ff;
      hash_in = hash_ff;
      key_in = key_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      byte_in = byte_ff;
      bit_in = bit_ff;
      done_in = 1'b0;
      trial = {rem_ff, hash_ff[HASH_W-1]};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               hash_in = HASH_SEED;
               key_in = key;
               div_in = divisor;
               byte_in = '0;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (key_ff[7:0] == 8'd0) begin
               rem_in = '0;
               bit_in = '0;
               state_in = ST_MOD;
            end else begin
               hash_in = ((hash_ff << 5) ^ hash_ff) ^ {24'd0, key_ff[7:0]};
               key_in = key_ff >> 8;
               byte_in = byte_ff + 3'd1;
               if (byte_ff == 3'd7) begin
                  rem_in = '0;
                  bit_in = '0;
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            hash_in = hash_ff << 1;
            if (trial >= {1'b0, div_ff}) begin
               rem_in = CNT_W'(trial - {1'b0, div_ff});
            end else begin
               rem_in = CNT_W'(trial);
            end
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'd31) begin
               done_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      hash_ff <= hash_in;
      key_ff <= key_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      byte_ff <= byte_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign bucket = rem_ff[IDX_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/chained_hash_name_lookup.sv
`default_nettype none
// Name directory lookup engine. A load item stores a name and size at an index
// and pushes it onto its hash bucket chain; a lookup item returns the matching
// entry, found by a chain walk (hashed mode) or a backward scan from the last
// entry (linear mode). One item is handled at a time. Any item that hashes
// first runs the byte-serial hash, then the bit-serial remainder, then hands
// the bucket over; a load then reads the bucket head and writes the entry and
// the new head, and a lookup reads the head, reads and compares each entry
// visited and then posts the result. A linear lookup skips the hash. Every item
// also passes through idle before the next one is accepted, and a result that
// is not taken stalls the next lookup in its last step. After reset a clearing
// pass over all 4096 bucket heads empties them while no item is accepted;
// register writes are taken throughout.
module chained_hash_name_lookup (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // entry_index [11:0], key_name [75:12], entry_size [106:76], zero pad
   input  wire logic [111:0]  req_tdata,
   // req_type [0]
   input  wire logic          req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // match_index [11:0], match_size [42:12], zero pad
   output logic      [47:0]   rsp_tdata,
   // found [0]
   output logic               rsp_tuser,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [2:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic      [31:0]   csr_prdata,
   output logic               csr_pready
);
   import chl_pkg::*;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_HASH, ST_LD_RD, ST_LD_WR,
      ST_LK_HEAD, ST_LK_RD, ST_LK_CMP, ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff;
   logic                 hashed_ff;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic                 type_ff, type_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [NAME_W-1:0]    key_ff, key_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [LINK_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]     steps_ff, steps_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [47:0]          rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]     eff_count;
   logic                 accept;
   logic                 hm_start;
   logic                 hm_done;
   logic [IDX_W-1:0]     bucket;
   logic                 head_we;
   logic [IDX_W-1:0]     head_waddr;
   logic [LINK_W-1:0]    head_wdata;
   logic [LINK_W-1:0]    head_rdata;
   logic                 ent_we;
   logic [ENTRY_W-1:0]   ent_wdata;
   logic [ENTRY_W-1:0]   ent_rdata;
   logic [NAME_W-1:0]    ent_name;
   logic [SIZE_W-1:0]    ent_size;
   logic [LINK_W-1:0]    ent_link;
   logic                 csr_write;

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(ENTRIES);
         hashed_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_ENTRY_COUNT) begin
            count_ff <= csr_pwdata[CNT_W-1:0];
         end else begin
            hashed_ff <= csr_pwdata[0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_HASHED_MODE) begin
         csr_prdata = {31'd0, hashed_ff};
      end else begin
         csr_prdata = {{(32 - CNT_W){1'b0}}, count_ff};
      end
   end

   // Count as used for the modulus and the scan start.
   always_comb begin
      if (count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (count_ff > CNT_W'(ENTRIES)) begin
         eff_count = CNT_W'(ENTRIES);
      end else begin
         eff_count = count_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign hm_start = accept && ((req_tuser == REQ_LOAD) || hashed_ff);

   chl_hash_mod u_hash_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (hm_start),
      .key     (req_tdata[75:12]),
      .divisor (eff_count),
      .done    (hm_done),
      .bucket  (bucket)
   );

   // Bucket heads: swept to empty after reset, then written by loads.
   assign head_we = (state_ff == ST_CLR) || (state_ff == ST_LD_WR);
   assign head_waddr = (state_ff == ST_CLR) ? clr_ff : bucket;
   assign head_wdata = (state_ff == ST_CLR) ? LINK_NONE : {1'b0, idx_ff};

   chl_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_heads (
      .clock (clock),
      .we    (head_we),
      .waddr (head_waddr),
      .wdata (head_wdata),
      .raddr (bucket),
      .rdata (head_rdata)
   );

   // Entries hold name, size and the link to the next entry of the chain.
   assign ent_we = (state_ff == ST_LD_WR);
   assign ent_wdata = {key_ff, size_ff, head_rdata};

   chl_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_entries (
      .clock (clock),
      .we    (ent_we),
      .waddr (idx_ff),
      .wdata (ent_wdata),
      .raddr (cur_ff[IDX_W-1:0]),
      .rdata (ent_rdata)
   );

   assign ent_name = ent_rdata[ENTRY_W-1 -: NAME_W];
   assign ent_size = ent_rdata[LINK_W +: SIZE_W];
   assign ent_link = ent_rdata[LINK_W-1:0];

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      type_in = type_ff;
      idx_in = idx_ff;
      key_in = key_ff;
      size_in = size_ff;
      cur_in = cur_ff;
      steps_in = steps_ff;
      hit_in = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               type_in = req_tuser;
               idx_in = req_tdata[IDX_W-1:0];
               key_in = req_tdata[75:12];
               size_in = req_tdata[106:76];
               steps_in = '0;
               hit_in = 1'b0;
               if (hm_start) begin
                  state_in = ST_HASH;
               end else begin
                  cur_in = eff_count - 1'b1;
                  state_in = ST_LK_RD;
               end
            end
         end
         ST_HASH: begin
            if (hm_done) begin
               state_in = (type_ff == REQ_LOAD) ? ST_LD_RD : ST_LK_HEAD;
            end
         end
         ST_LD_RD: state_in = ST_LD_WR;
         ST_LD_WR: state_in = ST_IDLE;
         ST_LK_HEAD: begin
            cur_in = head_rdata;
            state_in = head_rdata[IDX_W] ? ST_DONE : ST_LK_RD;
         end
         ST_LK_RD: state_in = ST_LK_CMP;
         ST_LK_CMP: begin
            if (name_canon(ent_name) == name_canon(key_ff)) begin
               hit_in = 1'b1;
               state_in = ST_DONE;
            end else if (hashed_ff) begin
               cur_in = ent_link;
               steps_in = steps_ff + 1'b1;
               if (ent_link[IDX_W] || (steps_ff == IDX_W'(ENTRIES - 1))) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LK_RD;
               end
            end else if (cur_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cur_in = cur_ff - 1'b1;
               state_in = ST_LK_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_data_in = hit_ff ? {5'd0, ent_size, cur_ff[IDX_W-1:0]} : '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff <= type_in;
      idx_ff <= idx_in;
      key_ff <= key_in;
      size_ff <= size_in;
      cur_ff <= cur_in;
      steps_ff <= steps_in;
      hit_ff <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_found_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
`default_nettype wire
